>>> rtl/cwps_pkg.sv
// Package for the centered window pause score block.
// Holds widths, reset constants and the structs passed between the front and back parts.
// No dependencies.
package cwps_pkg;

    localparam int SAMPLE_W       = 24;
    localparam int SCORE_W        = 24;
    localparam int WIN_W          = 6;
    localparam int PTR_W          = 6;
    localparam int DELAY_DEPTH    = 64;
    localparam int CNT_W          = 7;
    localparam int PEND_W         = 6;
    localparam int MAX_OUT        = 32;
    localparam int SUM_W          = 30;
    localparam int DVD_W          = 54;
    localparam int DVS_W          = 33;
    localparam int ROOT_W         = 27;
    localparam int MAX_WINDOW_DEF = 63;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [WIN_W-1:0]   WINDOW_RESET  = 6'd11;
    localparam logic [SCORE_W-1:0] SCORE_POS_MAX = 24'h7F_FFFF;
    localparam logic [SCORE_W-1:0] SCORE_NEG_MIN = 24'h80_0000;

    // One score job: a window of cnt samples starting at start, centered on center.
    typedef struct packed {
        logic [PTR_W-1:0] start;
        logic [WIN_W-1:0] cnt;
        logic [PTR_W-1:0] center;
        logic             last;
    } job_t;

    // Delay line write request from the front part.
    typedef struct packed {
        logic                en;
        logic [PTR_W-1:0]    addr;
        logic [SAMPLE_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               last;
    } result_t;

endpackage

>>> rtl/centered_window_pause_score.sv
// Throughput: a new sample is taken only once the previous one has been turned into jobs
// and the back part is idle; each score it releases runs through the shared divider
// (used twice) and the square root unit.
// Reset: asynchronous, active low; clears all counters, queues and window_size to 11.
// The delay line is not cleared; only samples of the current sequence are ever read.
module centered_window_pause_score #(
    parameter int MAX_WINDOW = cwps_pkg::MAX_WINDOW_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [cwps_pkg::SAMPLE_W-1:0]        coverage,
    input  logic                                 last_sample,
    input  logic                                 cfg_write,
    input  logic [cwps_pkg::WIN_W-1:0]           cfg_data,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [cwps_pkg::SCORE_W-1:0]  score,
    output logic                                 last_score
);
    import cwps_pkg::*;

    // The front part writes each sample into the delay line held by the back part and
    // turns every position with enough lookahead, or at a sequence end every pending one,
    // into a job. Jobs wait in a short queue; the back part sums the window, then runs mean,
    // root and the final quotient. A new transaction is taken only once all jobs of the last
    // one are finished, so the delay line is never overwritten under a window being summed.

    job_t    job_in;
    job_t    job_out;
    mem_wr_t mem_wr;
    result_t res_in;
    result_t res_out;
    logic    job_push;
    logic    job_pop;
    logic    job_full;
    logic    job_empty;
    logic    res_push;
    logic    res_full;
    logic    back_busy;

    cwps_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .coverage    (coverage),
        .last_sample (last_sample),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .back_busy   (back_busy),
        .job_empty   (job_empty),
        .job_full    (job_full),
        .job_push    (job_push),
        .job         (job_in),
        .mem_wr      (mem_wr)
    );

    // Queue between the two halves.
    cwps_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .empty   (job_empty)
    );

    cwps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mem_wr    (mem_wr),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in),
        .busy      (back_busy)
    );

    // Results wait here so the back part can start the next job while one is held.
    cwps_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign score      = res_out.score;
    assign last_score = res_out.last;

endmodule

>>> rtl/cwps_fifo.sv
// Small synchronous queue used for the job and result queues.
// Depends on nothing; DEPTH must be a power of two.
module cwps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [AW:0]      count_reg;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = store_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            store_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd_en && !empty)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
        end
    end

endmodule

>>> rtl/cwps_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on cwps_pkg for operand widths.
module cwps_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cwps_pkg::DVD_W-1:0] dividend,
    input  logic [cwps_pkg::DVS_W-1:0] divisor,
    output logic [cwps_pkg::DVD_W-1:0] quotient,
    output logic                      done
);
    import cwps_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  q_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVS_W:0]    trial;
    logic              ge;
    logic [DVS_W:0]    diff;

    assign trial    = {rem_reg, q_reg[DVD_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign diff     = trial - {1'b0, dvs_reg};
    assign quotient = q_reg;
    assign done     = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            q_reg   <= {q_reg[DVD_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/cwps_sqrt.sv
// Integer square root, two radicand bits per cycle.
// Depends on cwps_pkg for widths.
module cwps_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cwps_pkg::DVD_W-1:0]  radicand,
    output logic [cwps_pkg::ROOT_W-1:0] root,
    output logic                       done
);
    import cwps_pkg::*;

    localparam int STEP_W = $clog2(ROOT_W + 1);

    logic [DVD_W-1:0]  v_reg;
    logic [DVD_W-1:0]  res_reg;
    logic [DVD_W-1:0]  bit_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVD_W-1:0]  trial;

    assign trial = res_reg + bit_reg;
    assign root  = res_reg[ROOT_W-1:0];
    assign done  = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= DVD_W'(1) << (2 * ROOT_W - 2);
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/cwps_front.sv
// Front part: takes samples, keeps the sequence counters and issues one score job per
// position that falls due. Depends on cwps_pkg.
module cwps_front #(
    parameter int MAX_WINDOW = cwps_pkg::MAX_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [cwps_pkg::SAMPLE_W-1:0] coverage,
    input  logic                          last_sample,
    input  logic                          cfg_write,
    input  logic [cwps_pkg::WIN_W-1:0]    cfg_data,
    input  logic                          back_busy,
    input  logic                          job_empty,
    input  logic                          job_full,
    output logic                          job_push,
    output cwps_pkg::job_t                job,
    output cwps_pkg::mem_wr_t             mem_wr
);
    import cwps_pkg::*;

    typedef enum logic {
        F_IDLE,
        F_EMIT
    } fstate_t;

    fstate_t           state_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [CNT_W-1:0]  samp_cnt_reg;
    logic [PEND_W-1:0] pend_reg;
    logic              last_reg;

    logic              accept;
    logic [WIN_W-1:0]  win_eff;
    logic [WIN_W-1:0]  prev;
    logic [WIN_W-1:0]  next;
    logic [WIN_W-1:0]  back_ofs;
    logic [WIN_W-1:0]  ahead;
    logic [CNT_W-1:0]  behind_raw;
    logic [WIN_W-1:0]  behind;
    logic              due;

    assign full   = (state_reg != F_IDLE) || !job_empty || back_busy;
    assign accept = push && !full;

    assign mem_wr.en   = accept;
    assign mem_wr.addr = wr_ptr_reg;
    assign mem_wr.data = coverage;

    always_comb
    begin
        if (win_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (win_reg > WIN_W'(MAX_WINDOW))
        begin
            win_eff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = win_reg;
        end
        prev = win_eff >> 1;
        next = win_eff[0] ? prev : prev - 1'b1;

        back_ofs = pend_reg - 1'b1;
        ahead    = (back_ofs < next) ? back_ofs : next;
        if (samp_cnt_reg > {1'b0, back_ofs})
        begin
            behind_raw = samp_cnt_reg - 1'b1 - {1'b0, back_ofs};
        end
        else
        begin
            behind_raw = '0;
        end
        behind = (behind_raw > {1'b0, prev}) ? prev : behind_raw[WIN_W-1:0];

        job.center = wr_ptr_reg - 1'b1 - back_ofs;
        job.start  = job.center - behind;
        job.cnt    = ahead + behind + 1'b1;
        job.last   = last_reg && (pend_reg == PEND_W'(1));

        due      = last_reg ? (pend_reg != '0) : (pend_reg > next);
        job_push = (state_reg == F_EMIT) && due && !job_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            win_reg      <= WINDOW_RESET;
            wr_ptr_reg   <= '0;
            samp_cnt_reg <= '0;
            pend_reg     <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                win_reg <= cfg_data;
            end
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        wr_ptr_reg <= wr_ptr_reg + 1'b1;
                        if (samp_cnt_reg < CNT_W'(DELAY_DEPTH))
                        begin
                            samp_cnt_reg <= samp_cnt_reg + 1'b1;
                        end
                        if (pend_reg < PEND_W'(MAX_OUT))
                        begin
                            pend_reg <= pend_reg + 1'b1;
                        end
                        last_reg  <= last_sample;
                        state_reg <= F_EMIT;
                    end
                end
                F_EMIT:
                begin
                    if (!due)
                    begin
                        if (last_reg)
                        begin
                            pend_reg     <= '0;
                            samp_cnt_reg <= '0;
                        end
                        state_reg <= F_IDLE;
                    end
                    else if (job_push)
                    begin
                        pend_reg <= pend_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/cwps_back.sv
// Back part: holds the sample delay line, sums each job's window and computes the score
// with the shared divider and the square root unit. Depends on cwps_pkg, cwps_div, cwps_sqrt.
module cwps_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cwps_pkg::mem_wr_t    mem_wr,
    input  logic                 job_empty,
    input  cwps_pkg::job_t       job,
    output logic                 job_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output cwps_pkg::result_t    res,
    output logic                 busy
);
    import cwps_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SUM,
        B_MEAN,
        B_ROOT,
        B_QUOT,
        B_OUT
    } bstate_t;

    bstate_t             state_reg;
    job_t                job_reg;
    logic [WIN_W-1:0]    rd_cnt_reg;
    logic                rvld_reg;
    logic                rctr_reg;
    logic [SAMPLE_W-1:0] rdata_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] x_reg;
    logic [SUM_W-1:0]    xn_reg;
    logic [SUM_W-1:0]    num_reg;
    logic                neg_reg;
    logic [DVS_W-1:0]    den_reg;
    logic [DVD_W-1:0]    mean_reg;
    logic                div_start_reg;
    logic                sqrt_start_reg;
    logic [SCORE_W-1:0]  score_reg;

    logic [SAMPLE_W-1:0] delay_mem [DELAY_DEPTH];

    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;
    logic [DVD_W-1:0]    div_dividend;
    logic [DVS_W-1:0]    div_divisor;
    logic [DVD_W-1:0]    quotient;
    logic                div_done;
    logic [ROOT_W-1:0]   root;
    logic                sqrt_done;
    logic [DVS_W-1:0]    den_calc;

    assign rd_en    = (state_reg == B_SUM) && (rd_cnt_reg < job_reg.cnt);
    assign rd_addr  = job_reg.start + rd_cnt_reg;
    assign job_pop  = (state_reg == B_IDLE) && !job_empty;
    assign res_push = (state_reg == B_OUT) && !res_full;
    assign res.score = score_reg;
    assign res.last  = job_reg.last;
    assign busy     = (state_reg != B_IDLE);
    assign den_calc = DVS_W'(job_reg.cnt) * DVS_W'(root);

    always_comb
    begin
        if (state_reg == B_MEAN)
        begin
            div_dividend = {sum_reg, 24'd0};
            div_divisor  = DVS_W'(job_reg.cnt);
        end
        else
        begin
            div_dividend = DVD_W'({num_reg, 16'd0});
            div_divisor  = den_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            delay_mem[mem_wr.addr] <= mem_wr.data;
        end
        rdata_reg <= delay_mem[rd_addr];
    end

    cwps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    cwps_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (mean_reg),
        .root     (root),
        .done     (sqrt_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            rvld_reg       <= 1'b0;
            rctr_reg       <= 1'b0;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            rd_cnt_reg     <= '0;
            job_reg        <= '0;
            sum_reg        <= '0;
            x_reg          <= '0;
            xn_reg         <= '0;
            num_reg        <= '0;
            neg_reg        <= 1'b0;
            den_reg        <= '0;
            mean_reg       <= '0;
            score_reg      <= '0;
        end
        else
        begin
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            rvld_reg       <= rd_en;
            rctr_reg       <= (rd_addr == job_reg.center);
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!job_empty)
                    begin
                        job_reg    <= job;
                        rd_cnt_reg <= '0;
                        sum_reg    <= '0;
                        state_reg  <= B_SUM;
                    end
                end
                B_SUM:
                begin
                    if (rd_en)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                    if (rvld_reg)
                    begin
                        sum_reg <= sum_reg + SUM_W'(rdata_reg);
                        if (rctr_reg)
                        begin
                            x_reg <= rdata_reg;
                        end
                    end
                    else if (!rd_en && (rd_cnt_reg == job_reg.cnt))
                    begin
                        if (sum_reg == '0)
                        begin
                            score_reg <= '0;
                            state_reg <= B_OUT;
                        end
                        else
                        begin
                            xn_reg        <= SUM_W'(x_reg) * SUM_W'(job_reg.cnt);
                            div_start_reg <= 1'b1;
                            state_reg     <= B_MEAN;
                        end
                    end
                end
                B_MEAN:
                begin
                    if (div_done)
                    begin
                        mean_reg       <= quotient;
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= B_ROOT;
                    end
                end
                B_ROOT:
                begin
                    if (sqrt_done)
                    begin
                        neg_reg <= (xn_reg < sum_reg);
                        num_reg <= (xn_reg < sum_reg) ? sum_reg - xn_reg : xn_reg - sum_reg;
                        den_reg <= den_calc;
                        if (den_calc == '0)
                        begin
                            score_reg <= '0;
                            state_reg <= B_OUT;
                        end
                        else
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= B_QUOT;
                        end
                    end
                end
                B_QUOT:
                begin
                    if (div_done)
                    begin
                        if (neg_reg)
                        begin
                            if (quotient >= DVD_W'(SCORE_NEG_MIN))
                            begin
                                score_reg <= SCORE_NEG_MIN;
                            end
                            else
                            begin
                                score_reg <= ~quotient[SCORE_W-1:0] + 1'b1;
                            end
                        end
                        else if (quotient > DVD_W'(SCORE_POS_MAX))
                        begin
                            score_reg <= SCORE_POS_MAX;
                        end
                        else
                        begin
                            score_reg <= quotient[SCORE_W-1:0];
                        end
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (!res_full)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/cwps_checker.sv
// Port-level checks for the pause score block, bound to the top level.
// Depends on the top level's ports only.
module cwps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [23:0] score,
    input logic        last_score
);

    // Nothing waits on the result side while reset is held.
    assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty during reset");

    // An accepted sample keeps the input closed for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (push && !full) |=> full)
        else $error("input open right after a transaction");

    // With the block idle and no new sample, no result can appear.
    assert property (@(posedge clk) disable iff (!rst_n) (!full && !push) |=> !$fell(empty))
        else $error("result appeared without work in flight");

    // A waiting result that is not taken stays as it is.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(score) && $stable(last_score)))
        else $error("waiting result changed");

endmodule

bind centered_window_pause_score cwps_checker u_cwps_checker (.*);
